// ----- rtl/triangle_pwm_with_deadtime_assert.svh -----
// Assertion macros for the triangle PWM design file.
`ifndef TRIANGLE_PWM_WITH_DEADTIME_ASSERT_SVH
`define TRIANGLE_PWM_WITH_DEADTIME_ASSERT_SVH

`ifndef ASSERT_OFF
`define TPWM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpwm assertion failed");
`define TPWM_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tpwm forbidden condition seen");
`else
`define TPWM_ASSERT(name, clk, rst_n, prop)
`define TPWM_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ----- rtl/tpwm_pkg.sv -----
// Package with constants, register indexes and the period clamp helper of the triangle PWM.
`default_nettype none

package tpwm_pkg;

  localparam int unsigned PeriodW  = 16;
  localparam int unsigned DeadW    = 12;
  localparam int unsigned PhaseW   = 15;
  localparam int unsigned BlankW   = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgPeriod   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDeadtime = 2'd1;

  localparam logic [PeriodW-1:0] PeriodMin   = 16'd2;
  localparam logic [PeriodW-1:0] PeriodMax   = 16'd32768;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd1000;
  localparam logic [DeadW-1:0]   DeadReset   = 12'd10;

  function automatic logic [PeriodW-1:0] eff_period(input logic [PeriodW-1:0] raw);
    logic [PeriodW-1:0] res;
    if (raw < PeriodMin) begin
      res = PeriodMin;
    end else if (raw > PeriodMax) begin
      res = PeriodMax;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/triangle_pwm_with_deadtime.sv -----
// Center-aligned triangle PWM with dead time, one tick per input transaction.
//
//   ch   | dir | handshake               | payload
//   -----+-----+-------------------------+-----------------------------------------------------
//   in   | in  | in_valid_i/in_ready_o   | duty_level_i
//   out  | out | out_valid_o/out_ready_i | gate_high_o gate_low_o carrier_value_o sample_strobe_o
//   cfg  | in  | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// Each accepted transaction's result is registered and shown in the next cycle.
// A new tick is taken every cycle while the result register is empty or drained.
// A stall on the output holds the result and the tick state until it is taken.
// Reset clears the phase and blanks at least the first tick; no clearing pass is needed.
`default_nettype none

`include "triangle_pwm_with_deadtime_assert.svh"

module triangle_pwm_with_deadtime (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [15:0]                    duty_level_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                gate_high_o,
  output logic                                gate_low_o,
  output logic [15:0]                         carrier_value_o,
  output logic                                sample_strobe_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tpwm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tpwm_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [tpwm_pkg::PeriodW-1:0] period_q;
  logic [tpwm_pkg::DeadW-1:0]   dead_q;
  logic [tpwm_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [tpwm_pkg::PeriodW-1:0] last_carrier_q;
  logic                         falling_q, falling_d;
  logic                         last_falling_q;
  logic                         last_pwm_q;
  logic [tpwm_pkg::BlankW-1:0]  blank_q, blank_d, blank_eff;
  logic                         out_valid_q;
  logic                         gh_q, gl_q, strobe_q;
  logic [tpwm_pkg::PeriodW-1:0] carrier_q;

  logic                         in_acc;
  logic [tpwm_pkg::PeriodW-1:0] p_eff;
  logic [tpwm_pkg::PhaseW-1:0]  ph;
  logic [tpwm_pkg::PeriodW-1:0] twice;
  logic [tpwm_pkg::PeriodW-1:0] carrier;
  logic [tpwm_pkg::PeriodW-1:0] ph_inc;
  logic                         pwm;
  logic                         gh_d, gl_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    p_eff   = tpwm_pkg::eff_period(period_q);
    ph      = ({1'b0, phase_q} >= p_eff) ? '0 : phase_q;
    twice   = {ph, 1'b0};
    carrier = (twice >= p_eff) ? (twice - p_eff) : (p_eff - twice);
    falling_d = last_carrier_q > carrier;
    pwm     = duty_level_i > carrier;
    if (pwm != last_pwm_q) begin
      blank_eff = {1'b0, dead_q} + tpwm_pkg::BlankW'(1);
    end else begin
      blank_eff = blank_q;
    end
    if (blank_eff != '0) begin
      gh_d    = 1'b0;
      gl_d    = 1'b0;
      blank_d = blank_eff - tpwm_pkg::BlankW'(1);
    end else begin
      gh_d    = pwm;
      gl_d    = !pwm;
      blank_d = blank_eff;
    end
    ph_inc  = {1'b0, ph} + tpwm_pkg::PeriodW'(1);
    phase_d = (ph_inc >= p_eff) ? '0 : ph_inc[tpwm_pkg::PhaseW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= tpwm_pkg::PeriodReset;
      dead_q   <= tpwm_pkg::DeadReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tpwm_pkg::CfgPeriod:   period_q <= cfg_data_i;
        tpwm_pkg::CfgDeadtime: dead_q   <= cfg_data_i[tpwm_pkg::DeadW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= '0;
      last_carrier_q <= '0;
      falling_q      <= 1'b0;
      last_falling_q <= 1'b0;
      last_pwm_q     <= 1'b0;
      blank_q        <= tpwm_pkg::BlankW'(1);
    end else if (in_acc) begin
      phase_q        <= phase_d;
      last_carrier_q <= carrier;
      falling_q      <= falling_d;
      last_falling_q <= falling_q;
      last_pwm_q     <= pwm;
      blank_q        <= blank_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gh_q      <= gh_d;
      gl_q      <= gl_d;
      carrier_q <= carrier;
      strobe_q  <= falling_q != last_falling_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gate_high_o     = gh_q;
  assign gate_low_o      = gl_q;
  assign carrier_value_o = carrier_q;
  assign sample_strobe_o = strobe_q;

  `TPWM_ASSERT_NEVER(a_no_shoot_through, clk_i, rst_ni, out_valid_o && gate_high_o && gate_low_o)
  `TPWM_ASSERT(a_blank_gates_low, clk_i, rst_ni, (in_acc && blank_eff != '0) |=> (!gate_high_o && !gate_low_o))
  `TPWM_ASSERT(a_accept_gives_result, clk_i, rst_ni, in_acc |=> out_valid_o)

endmodule

`default_nettype wire
